>>> rtl/lbd_pkg.sv
package lbd_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int FILL_W       = WIN_AW + 1;
    localparam int LEN_BIAS     = 2;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

    // token lengths in bits, flag bit included
    localparam logic [4:0] LIT_BITS   = 5'd9;
    localparam logic [4:0] END_BITS   = 5'd13;
    localparam logic [4:0] MATCH_BITS = 5'd17;

    typedef enum logic [1:0] {
        K_NONE    = 2'd0,
        K_LITERAL = 2'd1,
        K_MATCH   = 2'd2,
        K_END     = 2'd3
    } t_kind;

    typedef struct packed {
        logic              begin_flag;
        t_kind             kind;
        logic [7:0]        literal;
        logic [WIN_AW-1:0] pos;
        logic [3:0]        len_code;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_COPY = 2'b10
    } t_be_state;

endpackage

>>> rtl/lbd_in_if.sv
interface lbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       begin_req;

    modport source (output valid, output in_byte, output begin_req, input ready);
    modport sink   (input valid, input in_byte, input begin_req, output ready);
endinterface

>>> rtl/lbd_out_if.sv
interface lbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_end;

    modport source (output valid, output out_byte, output last_of_run, output stream_end,
                    input ready);
    modport sink   (input valid, input out_byte, input last_of_run, input stream_end,
                    output ready);
endinterface

>>> rtl/lzss_bitstream_decoder_unit.sv
// LZSS decoder with a 4096-byte history window.
//
// i_in carries compressed words (in_byte, begin_req); o_out carries
// decompressed bytes with last_of_run and stream_end. Both use valid/ready,
// a word moves on a rising edge with valid and ready high.
// Bits are taken MSB first: flag 1 plus 8 bits is a literal, flag 0 plus a
// 12-bit window position and a 4-bit length code (length minus 2) is a
// match; a position of zero ends the stream, and words after the end are
// dropped until begin_req. begin_req restarts the stream with this word.
// The front parses one word per cycle into a two-entry command queue; the
// back copies one byte per cycle through the window's registered read port,
// forwarding the byte it writes in the same cycle.
// A word completes at most one token, which makes one result, or up to 17
// for the longest match; the back end takes the next command only once a
// copy is done, while the front keeps accepting words until the queue fills.
// Reset clears parse state, write position (to 1) and the fill count; the
// window reads as zero wherever it has not been written since begin, so no
// clearing pass is needed. A stall on o_out holds the back end and, once
// the queue fills, drops i_in.ready.
module lzss_bitstream_decoder_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lbd_in_if.sink    i_in,
    lbd_out_if.source o_out
);
    import lbd_pkg::*;

    logic w_push;
    t_cmd w_push_cmd;
    logic w_full;
    logic w_cmd_valid;
    t_cmd w_head_cmd;
    logic w_pop;

    // parse bits into tokens
    lbd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    // decouple parsing from copying
    lbd_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .o_valid (w_cmd_valid),
        .o_cmd   (w_head_cmd),
        .i_pop   (w_pop)
    );

    // run the window and emit bytes
    lbd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_head_cmd),
        .o_cmd_pop   (w_pop),
        .o_out       (o_out)
    );

endmodule

>>> rtl/lbd_front.sv
module lbd_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lbd_in_if.sink       i_in,
    input  logic         i_full,
    output logic         o_push,
    output lbd_pkg::t_cmd o_cmd
);
    import lbd_pkg::*;

    logic [16:0] r_bits, n_bits;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_flag, n_flag;
    logic        r_done, n_done;
    t_cmd        n_cmd;
    logic        w_accept;

    // walk the eight bits of the word, MSB first; at most one token completes
    always_comb begin
        logic stop;
        n_bits = r_bits;
        n_cnt  = r_cnt;
        n_flag = r_flag;
        n_done = r_done;
        n_cmd  = '0;
        n_cmd.kind = K_NONE;
        if (i_in.begin_req) begin
            n_bits = '0;
            n_cnt  = '0;
            n_flag = 1'b0;
            n_done = 1'b0;
        end
        n_cmd.begin_flag = i_in.begin_req;
        stop = n_done;
        for (int b = 7; b >= 0; b--) begin
            if (!stop) begin
                if (n_cnt == 5'd0) begin
                    n_flag = i_in.in_byte[b];
                end
                n_bits = {n_bits[15:0], i_in.in_byte[b]};
                n_cnt  = n_cnt + 5'd1;
                if (n_flag) begin
                    if (n_cnt >= LIT_BITS) begin
                        n_cmd.kind    = K_LITERAL;
                        n_cmd.literal = n_bits[7:0];
                        n_bits = '0;
                        n_cnt  = '0;
                    end
                end else if (n_cnt == END_BITS) begin
                    if (n_bits[WIN_AW-1:0] == '0) begin
                        n_cmd.kind = K_END;
                        n_done = 1'b1;
                        stop   = 1'b1;
                        n_bits = '0;
                        n_cnt  = '0;
                    end
                end else if (n_cnt >= MATCH_BITS) begin
                    n_cmd.kind     = K_MATCH;
                    n_cmd.pos      = n_bits[WIN_AW+3:4];
                    n_cmd.len_code = n_bits[3:0];
                    n_bits = '0;
                    n_cnt  = '0;
                end
            end
        end
    end

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && !i_full;
    assign o_push     = w_accept && (n_cmd.begin_flag || (n_cmd.kind != K_NONE));
    assign o_cmd      = n_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            r_cnt  <= '0;
            r_flag <= 1'b0;
            r_done <= 1'b0;
        end else if (w_accept) begin
            r_bits <= n_bits;
            r_cnt  <= n_cnt;
            r_flag <= n_flag;
            r_done <= n_done;
        end
    end

endmodule

>>> rtl/lbd_cmd_fifo.sv
module lbd_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lbd_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output lbd_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import lbd_pkg::*;

    t_cmd                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_fill;

    assign o_full  = (r_fill == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + (QUEUE_AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - (QUEUE_AW+1)'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("command queue underflow");

endmodule

>>> rtl/lbd_back.sv
module lbd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  lbd_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    lbd_out_if.source     o_out
);
    import lbd_pkg::*;

    logic [7:0]        r_win [WINDOW_DEPTH];
    logic [7:0]        r_rd;

    t_be_state         r_state;
    logic [WIN_AW-1:0] r_raddr;
    logic [4:0]        r_left;
    logic [WIN_AW-1:0] r_wp;
    logic [FILL_W-1:0] r_fill;

    // read stage: one byte waiting for the window write and the output register
    logic              r_pend;
    logic              r_pend_last;
    logic              r_pend_end;
    logic              r_pend_hit;
    logic              r_pend_written;
    logic [7:0]        r_fwd;

    logic              r_ovalid;
    logic [7:0]        r_obyte;
    logic              r_olast;
    logic              r_oend;

    logic              w_advance;
    logic              w_stage_free;
    logic              w_pop;
    logic              w_begin;
    logic              w_issue;
    logic              w_re;
    logic [WIN_AW-1:0] w_ra;
    logic              w_we;
    logic [7:0]        w_byte;
    logic              w_hit;
    logic              w_written;

    assign w_advance    = !r_ovalid || o_out.ready;
    assign w_stage_free = !r_pend || w_advance;
    assign w_pop        = (r_state == S_IDLE) && w_stage_free && i_cmd_valid;
    assign w_begin      = w_pop && i_cmd.begin_flag;
    assign w_issue      = (r_state == S_COPY) && w_stage_free;
    assign o_cmd_pop    = w_pop;

    assign w_we   = r_pend && w_advance && !r_pend_end;
    assign w_byte = r_pend_hit ? r_fwd : (r_pend_written ? r_rd : 8'd0);

    always_comb begin
        w_re = w_issue || (w_pop && (i_cmd.kind == K_MATCH));
        w_ra = w_issue ? r_raddr : i_cmd.pos;
    end

    // forward the byte written this cycle; entries not filled since begin read zero
    assign w_hit     = w_we && (w_ra == r_wp) && !w_begin;
    assign w_written = ({1'b0, w_ra - WIN_AW'(1)} < r_fill) && !w_begin;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_win[r_wp] <= w_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rd <= r_win[w_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop || w_issue) begin
            r_pend_written <= w_written;
            if (w_pop && (i_cmd.kind == K_LITERAL)) begin
                r_pend_hit <= 1'b1;
                r_fwd      <= i_cmd.literal;
            end else begin
                r_pend_hit <= w_hit;
                r_fwd      <= w_byte;
            end
        end
        if (w_pop && (i_cmd.kind == K_MATCH)) begin
            r_raddr <= i_cmd.pos + WIN_AW'(1);
            r_left  <= 5'({1'b0, i_cmd.len_code}) + 5'(LEN_BIAS - 1);
        end else if (w_issue) begin
            r_raddr <= r_raddr + WIN_AW'(1);
            r_left  <= r_left - 5'd1;
        end
        if (r_pend && w_advance) begin
            r_obyte <= r_pend_end ? 8'd0 : w_byte;
            r_olast <= r_pend_last;
            r_oend  <= r_pend_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_pend_end  <= 1'b0;
            r_wp        <= WIN_AW'(1);
            r_fill      <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_pop && (i_cmd.kind == K_MATCH)) begin
                        r_state <= S_COPY;
                    end
                end
                S_COPY: begin
                    if (w_issue && (r_left == 5'd1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (w_pop) begin
                r_pend      <= (i_cmd.kind != K_NONE);
                r_pend_end  <= (i_cmd.kind == K_END);
                r_pend_last <= (i_cmd.kind != K_MATCH);
            end else if (w_issue) begin
                r_pend      <= 1'b1;
                r_pend_end  <= 1'b0;
                r_pend_last <= (r_left == 5'd1);
            end else if (w_advance) begin
                r_pend <= 1'b0;
            end

            if (w_begin) begin
                r_wp   <= WIN_AW'(1);
                r_fill <= '0;
            end else if (w_we) begin
                r_wp <= r_wp + WIN_AW'(1);
                if (r_fill != FILL_W'(WINDOW_DEPTH)) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end

            if (r_pend && w_advance) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.out_byte    = r_obyte;
    assign o_out.last_of_run = r_olast;
    assign o_out.stream_end  = r_oend;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW_DEPTH))
        else $error("window fill count past depth");

    a_copy_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) |-> (r_left != 5'd0))
        else $error("copy running with no bytes left");

    a_begin_wp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_begin |=> (r_wp == WIN_AW'(1)) && (r_fill == '0))
        else $error("begin did not restart write position");

    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oend) |-> (r_olast && (r_obyte == 8'd0)))
        else $error("end result must be last and zero");

endmodule

>>> dv/lzss_bitstream_decoder_unit_tb.sv
`timescale 1ns / 1ps

module lzss_bitstream_decoder_unit_tb;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 3;
    localparam int STALL_LIMIT   = 2000;  // cycles with no word moving on either side
    localparam int HOLD_CYCLES   = 300;   // long back-pressure stretch on o_out
    localparam int HOLD_AT_BYTE  = 150;   // decoded byte count that starts it
    localparam int DRAIN_CYCLES  = 20;
    localparam int LONG_TOKENS   = 80;    // a long run of longest copies

    typedef struct packed {
        logic [7:0] data;
        logic       restart;
    } t_comp_word;

    typedef struct packed {
        logic [7:0] data;
        logic       last_of_run;
        logic       stream_end;
    } t_plain_word;

    logic clk;
    logic rst_n;

    lbd_in_if  in_bus ();
    lbd_out_if out_bus ();

    lzss_bitstream_decoder_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    t_comp_word  comp_words[$];      // compressed words waiting to be sent
    t_plain_word expected_bytes[$];  // decoded bytes still owed by the block
    bit          token_bits[$];      // bit string of the stream under construction

    // Shadow decoder state
    logic [7:0]  hist [lbd_pkg::WINDOW_DEPTH];
    logic [11:0] hist_wr;
    logic [16:0] tok_bits;
    logic [4:0]  tok_cnt;
    logic        ended;

    logic [11:0] gen_wr;  // rough write position seen by the stream builder
    int error_count;
    int words_sent;
    int words_queued;
    int bytes_seen;
    int in_gap;
    int out_gap;
    int in_calm;
    int out_calm;
    int quiet_cycles;
    int hold_left;
    bit hold_done;
    logic hold_off;

    // ------------------------------------------------------------------
    // Shadow decoder
    // ------------------------------------------------------------------
    function automatic void clear_history();
        foreach (hist[i]) hist[i] = 8'h00;
        hist_wr  = 12'd1;
        tok_bits = '0;
        tok_cnt  = '0;
        ended    = 1'b0;
    endfunction

    // Queue one decoded byte; ordinary bytes also land in the window.
    function automatic void push_result(logic [7:0] d, logic fin);
        t_plain_word r;
        r.data        = d;
        r.last_of_run = 1'b0;
        r.stream_end  = fin;
        expected_bytes.push_back(r);
        if (!fin) begin
            hist[hist_wr] = d;
            hist_wr       = hist_wr + 12'd1;
        end
    endfunction

    // Advance the shadow decoder by one accepted word.
    function automatic void decode_word(t_comp_word w);
        int          b;
        int          k;
        int          first_new;
        logic [11:0] rd;
        logic [4:0]  run_len;
        t_plain_word tail;
        first_new = expected_bytes.size();
        if (w.restart) clear_history();
        if (ended) return;
        for (b = 7; b >= 0 && !ended; b--) begin
            tok_bits = {tok_bits[15:0], w.data[b]};
            tok_cnt  = tok_cnt + 5'd1;
            if (tok_bits[tok_cnt - 5'd1]) begin
                // literal: flag plus eight data bits
                if (tok_cnt >= 5'd9) begin
                    push_result(tok_bits[7:0], 1'b0);
                    tok_bits = '0;
                    tok_cnt  = '0;
                end
            end else if (tok_cnt == 5'd13) begin
                // position zero ends the stream; rest of this word is dropped
                if (tok_bits[11:0] == 12'h000) begin
                    push_result(8'h00, 1'b1);
                    ended    = 1'b1;
                    tok_bits = '0;
                    tok_cnt  = '0;
                end
            end else if (tok_cnt == 5'd17) begin
                // copy byte by byte so overlapping copies repeat fresh data
                rd      = tok_bits[15:4];
                run_len = {1'b0, tok_bits[3:0]} + 5'd2;
                for (k = 0; k < run_len; k++) begin
                    push_result(hist[rd], 1'b0);
                    rd = rd + 12'd1;
                end
                tok_bits = '0;
                tok_cnt  = '0;
            end
        end
        // mark the final byte caused by this word
        if (expected_bytes.size() > first_new) begin
            tail             = expected_bytes.pop_back();
            tail.last_of_run = 1'b1;
            expected_bytes.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stream construction
    // ------------------------------------------------------------------
    function automatic void push_field(logic [15:0] v, int width);
        int i;
        for (i = width - 1; i >= 0; i--) token_bits.push_back(v[i]);
    endfunction

    function automatic void add_literal(logic [7:0] d);
        push_field(16'h0001, 1);
        push_field({8'h00, d}, 8);
        gen_wr = gen_wr + 12'd1;
    endfunction

    function automatic void add_match(logic [11:0] pos, logic [3:0] code);
        push_field(16'h0000, 1);
        push_field({4'h0, pos}, 12);
        push_field({12'h000, code}, 4);
        gen_wr = gen_wr + {8'h00, code} + 12'd2;
    endfunction

    function automatic void add_end();
        push_field(16'h0000, 13);
    endfunction

    function automatic void add_raw(logic [7:0] d, logic restart);
        t_comp_word w;
        w.data    = d;
        w.restart = restart;
        comp_words.push_back(w);
    endfunction

    // Pad to a word boundary with random bits and pack MSB first; the first
    // word of the stream carries begin_req.
    function automatic void close_stream();
        int i;
        int j;
        logic [7:0] d;
        while (token_bits.size() % 8 != 0) token_bits.push_back(1'($urandom_range(0, 1)));
        for (i = 0; token_bits.size() != 0; i++) begin
            for (j = 0; j < 8; j++) d = {d[6:0], token_bits.pop_front()};
            add_raw(d, i == 0);
        end
        gen_wr = 12'd1;
    endfunction

    function automatic void random_stream(int n_tok, bit all_long);
        int t;
        int i;
        logic [11:0] pos;
        logic [3:0]  code;
        for (t = 0; t < n_tok; t++) begin
            if (!all_long && $urandom_range(0, 9) < 4) begin
                add_literal(8'($urandom_range(0, 255)));
            end else begin
                code = (all_long || $urandom_range(0, 3) == 0) ? 4'hF
                                                               : 4'($urandom_range(0, 15));
                case ($urandom_range(0, 2))
                    0: pos = gen_wr - 12'($urandom_range(1, 20));   // short distance, often overlaps
                    1: pos = gen_wr - 12'($urandom_range(1, 300));
                    default: pos = 12'($urandom_range(1, 4095));
                endcase
                if (pos == 12'h000) pos = 12'h001;
                add_match(pos, code);
            end
        end
        if (all_long || $urandom_range(0, 2) != 0) begin
            add_end();
            push_field(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 7));
            close_stream();
            // words after the end are ignored until the next restart
            for (i = $urandom_range(0, 2); i > 0; i--) add_raw(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            // leave a token hanging; the next restart must discard it
            push_field(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 8));
            close_stream();
        end
    endfunction

    function automatic void noise_stream(int n);
        int i;
        add_raw(8'($urandom_range(0, 255)), 1'b1);
        for (i = 1; i < n; i++) add_raw(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
    endfunction

    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) calm = $urandom_range(15, 40);
        return $urandom_range(0, 8);
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        error_count++;
        $display("[%0t] mismatch at byte %0d: %s got %0h want %0h",
                 $realtime, bytes_seen, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Driver: send compressed words, random gap after each one
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_comp_word w;
        if (!rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                w.data    = in_bus.in_byte;
                w.restart = in_bus.begin_req;
                decode_word(w);
                words_sent++;
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_bus.valid <= 1'b0;
                end else if (comp_words.size() != 0) begin
                    w = comp_words.pop_front();
                    in_bus.valid     <= 1'b1;
                    in_bus.in_byte   <= w.data;
                    in_bus.begin_req <= w.restart;
                    in_gap = draw_wait(in_calm);
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each decoded byte, throttle ready
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_plain_word want;
        if (!rst_n) begin
            out_bus.ready <= 1'b0;
            out_gap = 0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch("unexpected byte", out_bus.out_byte, 8'h00);
                end else begin
                    want = expected_bytes.pop_front();
                    if (out_bus.out_byte !== want.data)
                        report_mismatch("out_byte", out_bus.out_byte, want.data);
                    if (out_bus.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", 8'(out_bus.last_of_run),
                                        8'(want.last_of_run));
                    if (out_bus.stream_end !== want.stream_end)
                        report_mismatch("stream_end", 8'(out_bus.stream_end),
                                        8'(want.stream_end));
                end
                bytes_seen++;
                out_gap = draw_wait(out_calm);
            end else if (out_gap > 0) begin
                out_gap--;
            end
            out_bus.ready <= (out_gap == 0) && !hold_off;
        end
    end

    // ------------------------------------------------------------------
    // Pressure: hold ready low long enough for the input side to back up
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left = 0;
            hold_done = 1'b0;
            hold_off <= 1'b0;
        end else begin
            if (!hold_done && bytes_seen >= HOLD_AT_BYTE) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end else if (hold_left > 0) begin
                hold_left--;
            end
            hold_off <= (hold_left > 0);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: give up when nothing moves for too long
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        in_bus.valid     = 1'b0;
        in_bus.in_byte   = 8'h00;
        in_bus.begin_req = 1'b0;
        out_bus.ready    = 1'b0;
        hold_off         = 1'b0;
        rst_n            = 1'b0;
        error_count      = 0;
        words_sent       = 0;
        bytes_seen       = 0;
        in_gap           = 0;
        out_gap          = 0;
        in_calm          = 0;
        out_calm         = 0;
        quiet_cycles     = 0;
        gen_wr           = 12'd1;
        clear_history();

        // Literals at both extremes, an overlapping longest copy, a copy whose
        // read address wraps, a short copy, then the end token with junk after.
        add_literal(8'hFF);
        add_literal(8'h00);
        add_literal(8'h5A);
        add_match(12'h001, 4'hF);
        add_match(12'hFFF, 4'h0);
        add_match(12'h002, 4'h1);
        add_end();
        push_field(16'h007F, 7);
        close_stream();
        add_raw(8'hFF, 1'b0);
        add_raw(8'h00, 1'b0);
        // Restart: the old window contents must be gone; leave a token open.
        add_literal(8'h81);
        add_match(12'h005, 4'h3);
        push_field(16'h0015, 6);
        close_stream();
        // End token right after a restart, then a word that is ignored.
        add_end();
        close_stream();
        add_raw(8'h3C, 1'b0);

        // Random streams, with one long run of longest copies in the middle.
        while (comp_words.size() < 100) begin
            if ($urandom_range(0, 9) == 0) noise_stream($urandom_range(4, 12));
            else random_stream($urandom_range(1, 12), 1'b0);
        end
        random_stream(LONG_TOKENS, 1'b1);
        while (comp_words.size() < 340) begin
            if ($urandom_range(0, 9) == 0) noise_stream($urandom_range(4, 12));
            else random_stream($urandom_range(1, 12), 1'b0);
        end
        words_queued = comp_words.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (words_sent < words_queued) @(negedge clk);
        while (expected_bytes.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
